FILE: hw/rtl/cise_pkg.sv
package cise_pkg;

	localparam int CP_W = 21;

	localparam logic [2:0] K_NONE  = 3'd0;
	localparam logic [2:0] K_PLAIN = 3'd1;
	localparam logic [2:0] K_FFFD  = 3'd2;
	localparam logic [2:0] K_BSL   = 3'd3;
	localparam logic [2:0] K_HEX   = 3'd4;

	localparam logic [CP_W-1:0] CP_NUL     = 21'h000000;
	localparam logic [CP_W-1:0] CP_REPL    = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_CTRL_HI = 21'h00001F;
	localparam logic [CP_W-1:0] CP_DEL     = 21'h00007F;
	localparam logic [CP_W-1:0] CP_NONASCII = 21'h000080;
	localparam logic [CP_W-1:0] CP_QUOTE   = 21'h000022;
	localparam logic [CP_W-1:0] CP_BSL     = 21'h00005C;
	localparam logic [CP_W-1:0] CP_SPACE   = 21'h000020;
	localparam logic [CP_W-1:0] CP_HYPHEN  = 21'h00002D;
	localparam logic [CP_W-1:0] CP_UNDER   = 21'h00005F;
	localparam logic [CP_W-1:0] CP_DIG_LO  = 21'h000030;
	localparam logic [CP_W-1:0] CP_DIG_HI  = 21'h000039;
	localparam logic [CP_W-1:0] CP_UC_LO   = 21'h000041;
	localparam logic [CP_W-1:0] CP_UC_HI   = 21'h00005A;
	localparam logic [CP_W-1:0] CP_LC_LO   = 21'h000061;
	localparam logic [CP_W-1:0] CP_LC_HI   = 21'h00007A;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_LATER  = 2'd2;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [2:0]      kind;
		logic            open_q;
		logic            close_q;
		logic            hex_two;
	} desc_t;

	function automatic logic [CP_W-1:0] hex_char(input logic [3:0] nib);
		logic [CP_W-1:0] r;
		if (nib < 4'd10) begin
			r = 21'h000030 + CP_W'(nib);
		end else begin
			r = 21'h000057 + CP_W'(nib);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/cise_front.sv
module cise_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,
	input  logic                      in_take,
	input  logic [cise_pkg::CP_W-1:0] code_point,
	input  logic                      first_char,
	input  logic                      last_char,
	input  logic                      empty_string,
	output logic                      desc_push,
	output cise_pkg::desc_t           desc
);

	logic       mode_q;
	logic [1:0] char_pos_q;
	logic       lead_hyph_q;

	logic [1:0] pos;
	logic       is_digit;
	logic       is_ctrl;
	logic       allowed;
	logic       is_hyph;
	logic [2:0] kind;
	logic [1:0] pos_nxt;
	logic       lh_nxt;

	always_comb begin
		pos      = (first_char || char_pos_q == cise_pkg::POS_FIRST) ? cise_pkg::POS_FIRST
			: char_pos_q;
		is_digit = code_point >= cise_pkg::CP_DIG_LO && code_point <= cise_pkg::CP_DIG_HI;
		is_ctrl  = code_point <= cise_pkg::CP_CTRL_HI || code_point == cise_pkg::CP_DEL;
		is_hyph  = code_point == cise_pkg::CP_HYPHEN;
		allowed  = code_point >= cise_pkg::CP_NONASCII || is_hyph
			|| code_point == cise_pkg::CP_UNDER || is_digit
			|| (code_point >= cise_pkg::CP_UC_LO && code_point <= cise_pkg::CP_UC_HI)
			|| (code_point >= cise_pkg::CP_LC_LO && code_point <= cise_pkg::CP_LC_HI);

		if (code_point == cise_pkg::CP_NUL) begin
			kind = cise_pkg::K_FFFD;
		end else if (is_ctrl) begin
			kind = cise_pkg::K_HEX;
		end else if (mode_q) begin
			kind = (code_point == cise_pkg::CP_QUOTE || code_point == cise_pkg::CP_BSL)
				? cise_pkg::K_BSL : cise_pkg::K_PLAIN;
		end else if (pos == cise_pkg::POS_FIRST && is_digit) begin
			kind = cise_pkg::K_HEX;
		end else if (pos == cise_pkg::POS_SECOND && lead_hyph_q && is_digit) begin
			kind = cise_pkg::K_HEX;
		end else if (pos == cise_pkg::POS_FIRST && is_hyph && last_char) begin
			kind = cise_pkg::K_BSL;
		end else if (allowed) begin
			kind = cise_pkg::K_PLAIN;
		end else begin
			kind = cise_pkg::K_BSL;
		end

		desc.cp      = code_point;
		desc.hex_two = code_point[cise_pkg::CP_W-1:4] != '0;
		if (empty_string) begin
			desc.kind    = cise_pkg::K_NONE;
			desc.open_q  = 1'b1;
			desc.close_q = 1'b1;
			desc_push    = in_take && mode_q;
		end else begin
			desc.kind    = kind;
			desc.open_q  = mode_q && pos == cise_pkg::POS_FIRST;
			desc.close_q = mode_q && last_char;
			desc_push    = in_take;
		end

		lh_nxt  = (pos == cise_pkg::POS_FIRST) ? is_hyph : lead_hyph_q;
		pos_nxt = (pos == cise_pkg::POS_LATER) ? cise_pkg::POS_LATER : pos + 2'd1;
		if (empty_string || last_char) begin
			lh_nxt  = 1'b0;
			pos_nxt = cise_pkg::POS_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			char_pos_q  <= cise_pkg::POS_FIRST;
			lead_hyph_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (in_take) begin
				char_pos_q  <= pos_nxt;
				lead_hyph_q <= lh_nxt;
			end
		end
	end

endmodule

FILE: hw/rtl/cise_queue.sv
module cise_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  cise_pkg::desc_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output cise_pkg::desc_t rd_data,
	output logic            rd_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cise_pkg::desc_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full     = count_q == CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/cise_back.sv
module cise_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      desc_valid,
	input  cise_pkg::desc_t           desc,
	output logic                      desc_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [cise_pkg::CP_W-1:0] out_code_point,
	output logic                      run_end
);

	logic                      out_valid_q;
	logic [cise_pkg::CP_W-1:0] out_cp_q;
	logic                      out_end_q;
	logic [2:0]                step_q;

	logic [2:0]                n_open;
	logic [2:0]                n_body;
	logic [2:0]                n_total;
	logic [2:0]                j;
	logic [3:0]                nib;
	logic [cise_pkg::CP_W-1:0] cp_sel;
	logic                      last_step;
	logic                      load;

	always_comb begin
		n_open = desc.open_q ? 3'd1 : 3'd0;
		case (desc.kind)
			cise_pkg::K_NONE:  n_body = 3'd0;
			cise_pkg::K_PLAIN: n_body = 3'd1;
			cise_pkg::K_FFFD:  n_body = 3'd1;
			cise_pkg::K_BSL:   n_body = 3'd2;
			cise_pkg::K_HEX:   n_body = desc.hex_two ? 3'd4 : 3'd3;
			default:           n_body = 3'd0;
		endcase
		n_total = n_open + n_body + (desc.close_q ? 3'd1 : 3'd0);
		j       = step_q - n_open;
		nib     = (desc.hex_two && j == 3'd1) ? desc.cp[7:4] : desc.cp[3:0];

		if (desc.open_q && step_q == 3'd0) begin
			cp_sel = cise_pkg::CP_QUOTE;
		end else if (j >= n_body) begin
			cp_sel = cise_pkg::CP_QUOTE;
		end else begin
			case (desc.kind)
				cise_pkg::K_PLAIN: cp_sel = desc.cp;
				cise_pkg::K_FFFD:  cp_sel = cise_pkg::CP_REPL;
				cise_pkg::K_BSL:   cp_sel = (j == 3'd0) ? cise_pkg::CP_BSL : desc.cp;
				cise_pkg::K_HEX: begin
					if (j == 3'd0) begin
						cp_sel = cise_pkg::CP_BSL;
					end else if (j == n_body - 3'd1) begin
						cp_sel = cise_pkg::CP_SPACE;
					end else begin
						cp_sel = cise_pkg::hex_char(nib);
					end
				end
				default:           cp_sel = cise_pkg::CP_QUOTE;
			endcase
		end

		last_step = step_q == n_total - 3'd1;
		load      = desc_valid && (!out_valid_q || pop);
		desc_pop  = load && last_step;
	end

	assign empty          = !out_valid_q;
	assign out_code_point = out_cp_q;
	assign run_end        = out_end_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_cp_q  <= cp_sel;
			out_end_q <= last_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				step_q <= last_step ? 3'd0 : step_q + 3'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/css_ident_string_escaper_unit.sv
// Channel  Direction  Handshake           Word
// input    in         push / full         code_point, first_char, last_char, empty_string
// result   out        empty / pop         out_code_point, run_end
// config   in         cfg_we              cfg_wdata (escape mode)
//
// One input word per cycle while the queue is not full; the expander gives out the result
// words of an item in order, and an item has 0 to 6 of them.
// The descriptor queue (QUEUE_DEPTH words) lets input run ahead while escapes expand.
// A result word passes through the descriptor queue and then the output register.
// Reset clears the queue, the output register, the string position and the mode.
module css_ident_string_escaper_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,
	input  logic                      push,
	output logic                      full,
	input  logic [cise_pkg::CP_W-1:0] code_point,
	input  logic                      first_char,
	input  logic                      last_char,
	input  logic                      empty_string,
	output logic                      empty,
	input  logic                      pop,
	output logic [cise_pkg::CP_W-1:0] out_code_point,
	output logic                      run_end
);

	logic            in_take;
	logic            desc_push;
	cise_pkg::desc_t desc_in;
	cise_pkg::desc_t desc_out;
	logic            desc_valid;
	logic            desc_pop;

	assign in_take = push && !full;

	cise_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_take      (in_take),
		.code_point   (code_point),
		.first_char   (first_char),
		.last_char    (last_char),
		.empty_string (empty_string),
		.desc_push    (desc_push),
		.desc         (desc_in)
	);

	cise_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (desc_push),
		.wr_data  (desc_in),
		.full     (full),
		.rd_en    (desc_pop),
		.rd_data  (desc_out),
		.rd_valid (desc_valid)
	);

	cise_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.desc_valid     (desc_valid),
		.desc           (desc_out),
		.desc_pop       (desc_pop),
		.empty          (empty),
		.pop            (pop),
		.out_code_point (out_code_point),
		.run_end        (run_end)
	);

endmodule
